FILE: rtl/tpih_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpih_pkg: shared types and constants
// Sizes, sequencer states and inter-module structs of the trace peak
// integral histogram core.
// ----------------------------------------------------------------------------
package tpih_pkg;

   // histogram geometry
   localparam int NUM_BINS = 512;
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int CNT_W    = $clog2(NUM_BINS + 1);

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int PEAK_W   = SAMPLE_W + 1;
   localparam int READ_W   = 9;
   localparam int COUNT_W  = 32;

   // running peak reset: most negative 13-bit value
   localparam logic signed [PEAK_W-1:0] PEAK_RESET = {1'b1, {(PEAK_W-1){1'b0}}};

   // input kind codes
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_READ
   } state_type;

   // histogram memory access
   typedef struct packed {
      logic               rd_en;
      logic [BIN_W-1:0]   rd_addr;
      logic               wr_en;
      logic [BIN_W-1:0]   wr_addr;
      logic [COUNT_W-1:0] wr_data;
   } mem_cmd_type;

   // end-of-trace request from the peak tracker
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] top;
   } walk_req_type;

endpackage

FILE: rtl/tpih_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpih_mem: histogram counter memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpih_mem (
   input  logic                         clock,
   input  tpih_pkg::mem_cmd_type        mem_cmd,
   output logic [tpih_pkg::COUNT_W-1:0] rd_data
);
   import tpih_pkg::*;

   logic [COUNT_W-1:0] mem_ff [NUM_BINS];
   logic [COUNT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_ff[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tpih_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpih_peak: baseline subtraction and running peak
// Tracks the peak of the current trace and, on its last sample, requests a
// histogram walk over the bins below the capped peak.
// ----------------------------------------------------------------------------
module tpih_peak (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sample_accept,
   input  logic [tpih_pkg::SAMPLE_W-1:0] sample_value,
   input  logic [tpih_pkg::SAMPLE_W-1:0] trace_baseline,
   input  logic                          last_sample,
   input  logic                          trace_triggered,
   input  logic                          use_trigger_gate,
   output tpih_pkg::walk_req_type        walk_req
);
   import tpih_pkg::*;

   logic signed [PEAK_W-1:0] peak_ff;
   logic signed [PEAK_W-1:0] peak_in;
   logic signed [PEAK_W-1:0] diff;
   logic signed [PEAK_W-1:0] new_peak;
   logic                     counted;

   // difference and peak compare
   always_comb begin
      diff     = $signed({1'b0, sample_value}) - $signed({1'b0, trace_baseline});
      new_peak = (diff > peak_ff) ? diff : peak_ff;
      counted  = !use_trigger_gate || trace_triggered;
   end

   // walk request with the peak capped at the bin count
   always_comb begin
      walk_req.start = sample_accept && last_sample && counted && (new_peak > 0);
      if (int'(new_peak) > NUM_BINS) begin
         walk_req.top = CNT_W'(NUM_BINS);
      end else if (new_peak > 0) begin
         walk_req.top = CNT_W'(new_peak);
      end else begin
         walk_req.top = '0;
      end
   end

   // next peak: restart after the last sample of a trace
   always_comb begin
      peak_in = peak_ff;
      if (sample_accept) begin
         peak_in = last_sample ? PEAK_RESET : new_peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= PEAK_RESET;
      end else begin
         peak_ff <= peak_in;
      end
   end

endmodule

FILE: rtl/tpih_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpih_seq: histogram sequencer
// Clears the memory after reset, walks the bins below a trace peak through
// one saturating incrementer, serves bin reads and holds the
// response register.
// ----------------------------------------------------------------------------
module tpih_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_kind,
   input  logic [tpih_pkg::READ_W-1:0]  req_read_bin,
   output logic                         req_stall,
   input  tpih_pkg::walk_req_type       walk_req,
   output tpih_pkg::mem_cmd_type        mem_cmd,
   input  logic [tpih_pkg::COUNT_W-1:0] rd_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tpih_pkg::COUNT_W-1:0] rsp_bin_count,
   output logic [tpih_pkg::READ_W-1:0]  rsp_bin_read
);
   import tpih_pkg::*;

   state_type          state_ff, state_in;
   logic [BIN_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   top_ff, top_in;
   logic [READ_W-1:0]  rd_bin_ff, rd_bin_in;
   logic               rd_hit_ff, rd_hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [READ_W-1:0]  rsp_bin_ff, rsp_bin_in;
   logic               req_accept;
   logic               bin_hit;
   logic [COUNT_W-1:0] count_inc;

   assign req_stall  = (state_ff != ST_IDLE) || (req_kind == KIND_READ && rsp_valid_ff);
   assign req_accept = req_valid && !req_stall;
   assign bin_hit    = 32'(req_read_bin) < 32'(NUM_BINS);

   // saturating incrementer for walk writes
   assign count_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_W'(1);

   // next state, memory commands and response load
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      top_in          = top_ff;
      rd_bin_in       = rd_bin_ff;
      rd_hit_in       = rd_hit_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_count_in    = rsp_count_ff;
      rsp_bin_in      = rsp_bin_ff;
      mem_cmd.rd_en   = 1'b0;
      mem_cmd.rd_addr = idx_ff;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_addr = idx_ff;
      mem_cmd.wr_data = count_inc;
      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_data = '0;
            idx_in          = idx_ff + BIN_W'(1);
            if (idx_ff == BIN_W'(NUM_BINS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_kind == KIND_READ) begin
               mem_cmd.rd_en   = bin_hit;
               mem_cmd.rd_addr = BIN_W'(req_read_bin);
               rd_bin_in       = req_read_bin;
               rd_hit_in       = bin_hit;
               state_in        = ST_READ;
            end else if (req_accept && walk_req.start) begin
               top_in   = walk_req.top;
               idx_in   = '0;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            mem_cmd.rd_en = 1'b1;
            state_in      = ST_WALK_WR;
         end
         ST_WALK_WR: begin
            mem_cmd.wr_en = 1'b1;
            if (CNT_W'(idx_ff) + CNT_W'(1) == top_ff) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + BIN_W'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = rd_hit_ff ? rd_data : '0;
            rsp_bin_in   = rd_bin_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      rd_bin_ff    <= rd_bin_in;
      rd_hit_ff    <= rd_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bin_ff   <= rsp_bin_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_count = rsp_count_ff;
   assign rsp_bin_read  = rsp_bin_ff;

`ifndef SYNTHESIS
   // transactions are taken only by an idle sequencer
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE)
      else $error("tpih_seq: transaction accepted while busy");

   // every bin write of a walk follows its read
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK_WR |-> $past(state_ff) == ST_WALK_RD)
      else $error("tpih_seq: walk write without read");

   // walk stays below the capped peak
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK_RD |-> CNT_W'(idx_ff) < top_ff)
      else $error("tpih_seq: walk past capped peak");

   // a bin read never overwrites a pending response
   a_read_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("tpih_seq: response register busy on read");
`endif

endmodule

FILE: rtl/trace_peak_integral_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_peak_integral_histogram_core: pulse-height integral spectrum
// Tracks the baseline-corrected peak of each trace and counts it into a
// saturating integral histogram; read transactions return one bin count.
// ----------------------------------------------------------------------------
// After reset the core zeroes every bin of the histogram memory and stalls
// requests meanwhile; the configuration port is always ready. The last
// sample of a counted trace with peak p starts a walk over the bins below
// min(p, 512); a single read-increment-write path into the one-port-each
// counter memory handles each bin with a read state and then a write
// state; peaks at or below zero add nothing. A read transaction passes
// through a memory read and a response load and is held off while an
// earlier response still waits to be taken, while samples keep flowing.
// ----------------------------------------------------------------------------
module trace_peak_integral_histogram_core (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [tpih_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [tpih_pkg::SAMPLE_W-1:0] req_trace_baseline,
   input  logic                          req_last_sample,
   input  logic                          req_trace_triggered,
   input  logic [tpih_pkg::READ_W-1:0]   req_read_bin,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tpih_pkg::COUNT_W-1:0]  rsp_bin_count,
   output logic [tpih_pkg::READ_W-1:0]   rsp_bin_read,
   // control register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_use_trigger_gate
);
   import tpih_pkg::*;

   logic               gate_ff;
   logic               sample_accept;
   walk_req_type       walk_req;
   mem_cmd_type        mem_cmd;
   logic [COUNT_W-1:0] rd_data;

   // gating register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         gate_ff <= csr_use_trigger_gate;
      end
   end

   assign sample_accept = req_valid && !req_stall && req_kind == KIND_SAMPLE;

   tpih_peak u_peak (
      .clock            (clock),
      .reset            (reset),
      .sample_accept    (sample_accept),
      .sample_value     (req_sample_value),
      .trace_baseline   (req_trace_baseline),
      .last_sample      (req_last_sample),
      .trace_triggered  (req_trace_triggered),
      .use_trigger_gate (gate_ff),
      .walk_req         (walk_req)
   );

   tpih_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   tpih_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_kind      (req_kind),
      .req_read_bin  (req_read_bin),
      .req_stall     (req_stall),
      .walk_req      (walk_req),
      .mem_cmd       (mem_cmd),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_count (rsp_bin_count),
      .rsp_bin_read  (rsp_bin_read)
   );

endmodule
